// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/bprlp_pkg.sv
// ----------------------------------------------------------------------------
// Bit-packed run-length packer package
// Shared constants, types and small helper functions.
// ----------------------------------------------------------------------------
package bprlp_pkg;

  localparam int MAX_RUN_DEF      = 128;
  localparam int WINDOW_DEPTH_DEF = 256;

  localparam int SYM_W      = 8;
  localparam int DEPTH_W    = 4;
  localparam int LIMIT_W    = 24;
  localparam int BCNT_W     = 25;
  localparam int WORD_W     = 64;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_DEPTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT   = 1'b1;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'hFFFFFF;

  typedef enum logic [1:0] {
    OP_UNIT,
    OP_PAD,
    OP_FIN1,
    OP_FIN2
  } op_kind_e;

  typedef struct packed {
    logic             vld;
    op_kind_e         kind;
    logic [SYM_W-1:0] value;
    logic [3:0]       nbits;
    logic             end_mode;
  } emit_op_t;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
    logic               ovf;
    logic               last;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic scan_load;
    logic scan_shift;
  } cell_ctrl_t;

  // Depth 0 is coded as 1 and anything above 8 as 8.
  function automatic logic [3:0] depth_clamp(input logic [DEPTH_W-1:0] d);
    logic [3:0] r;
    if (d == 4'd0) begin
      r = 4'd1;
    end else if (d > 4'd8) begin
      r = 4'd8;
    end else begin
      r = d;
    end
    return r;
  endfunction

  // Shortest run that is worth coding as a repeat at a given depth.
  function automatic logic [3:0] run_threshold(input logic [3:0] d);
    logic [3:0] r;
    unique case (d)
      4'd1:    r = 4'd10;
      4'd2:    r = 4'd6;
      4'd3:    r = 4'd4;
      4'd4:    r = 4'd4;
      default: r = 4'd3;
    endcase
    return r;
  endfunction

  function automatic logic [SYM_W-1:0] sym_mask(input logic [3:0] d);
    logic [8:0] m;
    m = (9'd1 << d) - 9'd1;
    return m[SYM_W-1:0];
  endfunction

endpackage

// File: rtl/bprlp_cell.sv
// ----------------------------------------------------------------------------
// Lookahead window cell
// Holds one window symbol and one scan flag pair; shifts towards the head.
// ----------------------------------------------------------------------------
module bprlp_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bprlp_pkg::cell_ctrl_t       ctrl_i,
  input  logic                        load_here_i,
  input  logic [bprlp_pkg::SYM_W-1:0] in_sym_i,
  input  logic [bprlp_pkg::SYM_W-1:0] nxt_sym_i,
  input  logic                        nxt_vld_i,
  input  logic                        scan_f_i,
  input  logic                        scan_v_i,
  input  logic                        nxt_f_i,
  input  logic                        nxt_fv_i,
  output logic [bprlp_pkg::SYM_W-1:0] sym_o,
  output logic                        vld_o,
  output logic                        eq_o,
  output logic                        f_o,
  output logic                        fv_o
);

  logic [bprlp_pkg::SYM_W-1:0] sym_q;
  logic                        vld_q;
  logic                        f_q;
  logic                        fv_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && load_here_i) begin
      sym_q <= in_sym_i;
    end else if (ctrl_i.pop) begin
      sym_q <= nxt_sym_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      f_q   <= 1'b0;
      fv_q  <= 1'b0;
    end else begin
      if (ctrl_i.push && load_here_i) begin
        vld_q <= 1'b1;
      end else if (ctrl_i.pop) begin
        vld_q <= nxt_vld_i;
      end
      if (ctrl_i.scan_load) begin
        f_q  <= scan_f_i;
        fv_q <= scan_v_i;
      end else if (ctrl_i.scan_shift) begin
        f_q  <= nxt_f_i;
        fv_q <= nxt_fv_i;
      end
    end
  end

  assign sym_o = sym_q;
  assign vld_o = vld_q;
  assign eq_o  = vld_q & nxt_vld_i & (sym_q == nxt_sym_i);
  assign f_o   = f_q;
  assign fv_o  = fv_q;

endmodule

// File: rtl/bprlp_emitter.sv
// ----------------------------------------------------------------------------
// Bit packer and word emitter
// Packs codes MSB first into bytes, bytes into 64-bit words, checks the limit.
// ----------------------------------------------------------------------------
module bprlp_emitter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bprlp_pkg::emit_op_t           op_i,
  input  logic [bprlp_pkg::LIMIT_W-1:0] byte_limit_i,
  output logic                          ready_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output bprlp_pkg::result_t            res_o
);

  logic [6:0]                          acc_q, acc_d;
  logic [2:0]                          held_q, held_d;
  logic [bprlp_pkg::WORD_W-1:0]        word_q, word_d;
  logic [2:0]                          wb_q, wb_d;
  logic [bprlp_pkg::BCNT_W-1:0]        bw_q, bw_d;
  logic                                ovf_q, ovf_d;
  bprlp_pkg::result_t                  hold_q, hold_d;
  logic                                hold_vld_q, hold_vld_d;
  bprlp_pkg::result_t                  out_q, out_d;
  logic                                out_vld_q, out_vld_d;

  logic                                take;
  logic [3:0]                          nbits;
  logic [bprlp_pkg::SYM_W-1:0]         val;
  logic [15:0]                         cat;
  logic [4:0]                          tot;
  logic [2:0]                          nh;
  logic [7:0]                          byte_v;
  logic [bprlp_pkg::WORD_W-1:0]        wfull;
  bprlp_pkg::result_t                  r;
  logic                                r_vld;
  bprlp_pkg::result_t                  ld_res;
  logic                                ld;

  assign ready_o = !out_vld_q || out_ready_i;
  assign take    = op_i.vld && ready_o;

  always_comb begin
    acc_d      = acc_q;
    held_d     = held_q;
    word_d     = word_q;
    wb_d       = wb_q;
    bw_d       = bw_q;
    ovf_d      = ovf_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    r          = '0;
    r_vld      = 1'b0;
    ld         = 1'b0;
    ld_res     = '0;

    if (op_i.kind == bprlp_pkg::OP_PAD) begin
      nbits = (held_q == 3'd0) ? 4'd0 : (4'd8 - {1'b0, held_q});
      val   = '0;
    end else begin
      nbits = op_i.nbits;
      val   = op_i.value;
    end
    cat    = (16'(acc_q) << nbits) | 16'(val);
    tot    = 5'(held_q) + 5'(nbits);
    nh     = tot[2:0];
    byte_v = 8'(cat >> nh);
    wfull  = word_q | (64'(byte_v) << {~wb_q, 3'b000});

    if (take) begin
      unique case (op_i.kind)
        bprlp_pkg::OP_UNIT, bprlp_pkg::OP_PAD: begin
          acc_d  = 7'(cat & ((16'd1 << nh) - 16'd1));
          held_d = nh;
          if (tot[3] && !ovf_q) begin
            if (bw_q >= 25'(byte_limit_i)) begin
              ovf_d  = 1'b1;
              word_d = '0;
              wb_d   = '0;
              r      = '{word: '0, count: '0, ovf: 1'b1, last: 1'b1};
              r_vld  = 1'b1;
            end else begin
              bw_d = bw_q + 25'd1;
              if (wb_q == 3'd7) begin
                r      = '{word: wfull, count: 4'd8, ovf: 1'b0, last: 1'b0};
                r_vld  = 1'b1;
                word_d = '0;
                wb_d   = '0;
              end else begin
                word_d = wfull;
                wb_d   = wb_q + 3'd1;
              end
            end
          end
        end
        bprlp_pkg::OP_FIN1: begin
          if (!ovf_q && wb_q != 3'd0) begin
            r     = '{word: word_q, count: {1'b0, wb_q}, ovf: 1'b0, last: 1'b0};
            r_vld = 1'b1;
          end
        end
        bprlp_pkg::OP_FIN2: begin
          if (hold_vld_q) begin
            ld          = 1'b1;
            ld_res      = hold_q;
            ld_res.last = 1'b1;
          end
          hold_vld_d = 1'b0;
          acc_d      = '0;
          held_d     = '0;
          word_d     = '0;
          wb_d       = '0;
          bw_d       = '0;
          ovf_d      = 1'b0;
        end
        default: ;
      endcase
    end

    // At the end of a block the newest result is held back so that the
    // final one can be marked as last.
    if (r_vld) begin
      if (op_i.end_mode) begin
        if (hold_vld_q) begin
          ld     = 1'b1;
          ld_res = hold_q;
        end
        hold_d     = r;
        hold_vld_d = 1'b1;
      end else begin
        ld     = 1'b1;
        ld_res = r;
      end
    end

    out_vld_d = (out_vld_q && !out_ready_i) || ld;
    out_d     = ld ? ld_res : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      held_q     <= '0;
      word_q     <= '0;
      wb_q       <= '0;
      bw_q       <= '0;
      ovf_q      <= 1'b0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      held_q     <= held_d;
      word_q     <= word_d;
      wb_q       <= wb_d;
      bw_q       <= bw_d;
      ovf_q      <= ovf_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

// File: rtl/bit_packed_run_length_packer_unit.sv
// ----------------------------------------------------------------------------
// Bit-packed run-length packer
// PackBits-style coder of palette symbols into MSB-first 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Symbols enter on the in_* valid/ready channel, one per transaction, the
//   last symbol of a block marked by end_of_block_i. Packed words leave on the
//   out_* valid/ready channel with byte_count_o valid bytes, first byte in
//   bits 63 to 56. overflow_o flags a block that passed the byte limit; such
//   a block gives no further words and must be discarded.
//   Symbols sit in a chain of cells that forms the lookahead window. Each code
//   is found by shifting a flag chain one cell per cycle and then sent by
//   shifting the symbols out one per cycle unless the emitter stalls. Input
//   is taken only in the idle state, so a new symbol waits until the last one
//   has been handled.
//   Reset empties the window and clears the packer; depth returns to 8 and the
//   byte limit to its maximum. No clearing pass is needed. When the receiver
//   stalls, the output register holds its word and the coder waits; input is
//   taken again once the pending code is sent. The user writes configuration
//   via cfg_we_i only while the block is idle; the block does not check this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bit_packed_run_length_packer_unit #(
  parameter int MAX_RUN      = bprlp_pkg::MAX_RUN_DEF,
  parameter int WINDOW_DEPTH = bprlp_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bprlp_pkg::SYM_W-1:0]      symbol_i,
  input  logic                             end_of_block_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bprlp_pkg::WORD_W-1:0]     packed_word_o,
  output logic [bprlp_pkg::COUNT_W-1:0]    byte_count_o,
  output logic                             overflow_o,
  output logic                             last_o,
  input  logic                             cfg_we_i,
  input  logic [bprlp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bprlp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LOOKAHEAD = (2 * MAX_RUN - 1) < WINDOW_DEPTH ? (2 * MAX_RUN - 1)
                                                               : WINDOW_DEPTH;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CNT_W  = $clog2(MAX_RUN + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_CTRL,
    S_LIT,
    S_RSYM,
    S_DROP,
    S_PAD,
    S_FIN1,
    S_FIN2
  } state_e;

  state_e                          state_q;
  logic [FILL_W-1:0]               fill_q;
  logic [CNT_W-1:0]                cnt_q;
  logic                            mode_q;
  logic                            end_q;
  logic [bprlp_pkg::DEPTH_W-1:0]   depth_q;
  logic [bprlp_pkg::LIMIT_W-1:0]   limit_q;

  logic [3:0]                      depth_eff;
  logic [3:0]                      thr;
  logic                            thr_ok;
  logic [bprlp_pkg::SYM_W-1:0]     sym_mask_v;

  logic [bprlp_pkg::SYM_W-1:0]     sym   [WINDOW_DEPTH+1];
  logic [WINDOW_DEPTH:0]           vld;
  logic [WINDOW_DEPTH+8:0]         eq;
  logic [WINDOW_DEPTH:0]           wrth;
  logic [WINDOW_DEPTH:0]           f;
  logic [WINDOW_DEPTH:0]           fv;

  bprlp_pkg::cell_ctrl_t           ctrl;
  bprlp_pkg::emit_op_t             op;
  bprlp_pkg::result_t              res;
  logic                            e_rdy;
  logic                            accept;
  logic                            cont;
  logic                            do_code;
  logic [7:0]                      ctrl_byte;

  assign depth_eff  = bprlp_pkg::depth_clamp(depth_q);
  assign thr        = bprlp_pkg::run_threshold(depth_eff);
  assign thr_ok     = 32'(thr) <= MAX_RUN;
  assign sym_mask_v = bprlp_pkg::sym_mask(depth_eff);

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o = (state_q == S_IDLE);

  // Padding beyond the last cell reads as empty.
  assign sym[WINDOW_DEPTH] = '0;
  assign vld[WINDOW_DEPTH] = 1'b0;
  assign f[WINDOW_DEPTH]   = 1'b0;
  assign fv[WINDOW_DEPTH]  = 1'b0;
  assign eq[WINDOW_DEPTH+8:WINDOW_DEPTH] = '0;

  // A cell starts a worthwhile run when the next thr-1 neighbours are equal.
  always_comb begin
    for (int k = 0; k <= WINDOW_DEPTH; k++) begin
      wrth[k] = thr_ok;
      for (int j = 0; j < 9; j++) begin
        if ((j + 1 < int'(thr)) && !eq[k+j]) begin
          wrth[k] = 1'b0;
        end
      end
    end
  end

  assign ctrl.push       = accept;
  assign ctrl.pop        = ((state_q == S_LIT || state_q == S_RSYM) && e_rdy)
                           || (state_q == S_DROP);
  assign ctrl.scan_load  = (state_q == S_DECIDE);
  assign ctrl.scan_shift = (state_q == S_SCAN) && cont;

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    bprlp_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .load_here_i (fill_q == FILL_W'(k)),
      .in_sym_i    (symbol_i),
      .nxt_sym_i   (sym[k+1]),
      .nxt_vld_i   (vld[k+1]),
      .scan_f_i    (wrth[0] ? eq[k] : wrth[k+1]),
      .scan_v_i    (vld[k+1]),
      .nxt_f_i     (f[k+1]),
      .nxt_fv_i    (fv[k+1]),
      .sym_o       (sym[k]),
      .vld_o       (vld[k]),
      .eq_o        (eq[k]),
      .f_o         (f[k]),
      .fv_o        (fv[k])
    );
  end

  // A repeat run grows while the head flag shows equal neighbours, a literal
  // one until the window ends or a worthwhile run starts; MAX_RUN caps both.
  assign cont = (cnt_q != CNT_W'(MAX_RUN)) && (mode_q ? f[0] : (fv[0] && !f[0]));

  assign do_code = end_q ? (fill_q != '0) : (32'(fill_q) >= LOOKAHEAD);

  assign ctrl_byte = mode_q ? 8'(9'd257 - 9'(cnt_q)) : 8'(cnt_q - CNT_W'(1));

  always_comb begin
    op          = '0;
    op.end_mode = end_q;
    unique case (state_q)
      S_CTRL: begin
        op.vld   = 1'b1;
        op.kind  = bprlp_pkg::OP_UNIT;
        op.value = ctrl_byte;
        op.nbits = 4'd8;
      end
      S_LIT, S_RSYM: begin
        op.vld   = 1'b1;
        op.kind  = bprlp_pkg::OP_UNIT;
        op.value = sym[0] & sym_mask_v;
        op.nbits = depth_eff;
      end
      S_PAD: begin
        op.vld  = 1'b1;
        op.kind = bprlp_pkg::OP_PAD;
      end
      S_FIN1: begin
        op.vld  = 1'b1;
        op.kind = bprlp_pkg::OP_FIN1;
      end
      S_FIN2: begin
        op.vld  = 1'b1;
        op.kind = bprlp_pkg::OP_FIN2;
      end
      default: ;
    endcase
  end

  bprlp_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .byte_limit_i (limit_q),
    .ready_o      (e_rdy),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .res_o        (res)
  );

  assign packed_word_o = res.word;
  assign byte_count_o  = res.count;
  assign overflow_o    = res.ovf;
  assign last_o        = res.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
      mode_q  <= 1'b0;
      end_q   <= 1'b0;
      depth_q <= bprlp_pkg::DEPTH_RESET;
      limit_q <= bprlp_pkg::LIMIT_RESET;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bprlp_pkg::CFG_SYMBOL_DEPTH: depth_q <= cfg_data_i[bprlp_pkg::DEPTH_W-1:0];
          bprlp_pkg::CFG_BYTE_LIMIT:   limit_q <= cfg_data_i[bprlp_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            fill_q  <= fill_q + FILL_W'(1);
            end_q   <= end_of_block_i;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (do_code) begin
            mode_q  <= wrth[0];
            cnt_q   <= CNT_W'(1);
            state_q <= S_SCAN;
          end else if (end_q) begin
            state_q <= S_PAD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (cont) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end else begin
            state_q <= S_CTRL;
          end
        end
        S_CTRL: begin
          if (e_rdy) begin
            state_q <= mode_q ? S_RSYM : S_LIT;
          end
        end
        S_LIT: begin
          if (e_rdy) begin
            fill_q <= fill_q - FILL_W'(1);
            cnt_q  <= cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              state_q <= S_DECIDE;
            end
          end
        end
        S_RSYM: begin
          if (e_rdy) begin
            fill_q  <= fill_q - FILL_W'(1);
            cnt_q   <= cnt_q - CNT_W'(1);
            state_q <= S_DROP;
          end
        end
        S_DROP: begin
          fill_q <= fill_q - FILL_W'(1);
          cnt_q  <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= S_DECIDE;
          end
        end
        S_PAD: begin
          if (e_rdy) begin
            state_q <= S_FIN1;
          end
        end
        S_FIN1: begin
          if (e_rdy) begin
            state_q <= S_FIN2;
          end
        end
        S_FIN2: begin
          if (e_rdy) begin
            end_q   <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, 32'(fill_q) <= LOOKAHEAD)
  `ASSERT_IMP(a_head_valid, clk_i, rst_ni, 1'b1, (fill_q != '0) == vld[0])
  `ASSERT_IMP(a_ovf_last, clk_i, rst_ni, out_valid_o && overflow_o, last_o)
  `ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule
